@@ rtl/pse_pkg.sv @@
// Package: shared types, constants and saturation helpers for the postfix evaluator.
`default_nettype none
package pse_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int QUO_W  = WORD_W + FRAC_W;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4,
    OP_FINISH = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_MISSING = 3'd1,
    ST_FULL    = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_EMPTY   = 3'd4
  } st_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV
  } bst_t;

  typedef struct packed {
    op_t               kind;
    logic [WORD_W-1:0] value;
  } tok_t;

  function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
  endfunction

  function automatic logic [WORD_W-1:0] sat_sum(input logic [WORD_W:0] s);
    logic [WORD_W-1:0] r;
    if (s[WORD_W] != s[WORD_W-1]) begin
      r = s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      r = s[WORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] sat_mag(input logic [QUO_W-1:0] m, input logic neg);
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] mm;
    lim = neg ? (QUO_W'(1) << (WORD_W-1)) : ((QUO_W'(1) << (WORD_W-1)) - QUO_W'(1));
    mm  = (m > lim) ? lim : m;
    return neg ? (~mm[WORD_W-1:0] + WORD_W'(1)) : mm[WORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/pse_ifs.sv @@
// Interfaces: token input channel and result output channel.
`default_nettype none
interface pse_tok_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic signed [31:0] operand_value;
  modport source (output valid, output cmd, output operand_value, input ready);
  modport sink   (input valid, input cmd, input operand_value, output ready);
endinterface

interface pse_res_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic [2:0]  status;
  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface
`default_nettype wire

@@ rtl/postfix_stack_evaluator_top.sv @@
// Top level: postfix expression evaluator on a signed Q16.16 operand stack.
// Push finishes in the idle state; add/sub go through execute, multiply then MUL,
//   divide then DIV (48 quotient bits from the restoring divider, one per cycle).
// Finish loads the result register at the edge that pops it from the queue.
// Throughput: one token per cycle into the two-entry queue while not full; the sequencer sets the pace.
// Reset (synchronous, rst high) empties the queue, the stack count and the error.
`default_nettype none
module postfix_stack_evaluator_top
  import pse_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  pse_tok_if.sink   tok,
  pse_res_if.source res
);
  // decoded tokens wait in the front queue while the back end is busy
  logic q_valid;
  logic q_pop;
  tok_t q_data;

  // front: decodes cmd, drops unused codes, buffers two tokens
  pse_front u_front (
    .clk     (clk),
    .rst     (rst),
    .tok     (tok),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  // back: top of stack in a register, the rest in RAM; saturating arithmetic;
  // the first error is held until finish, which reports and clears the stack
  pse_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .res     (res)
  );
endmodule
`default_nettype wire

@@ rtl/pse_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/pse_front.sv @@
// Front end: token decode and a two-entry queue towards the execution unit.
`default_nettype none
module pse_front
  import pse_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  pse_tok_if.sink   tok,
  output logic      q_valid,
  output tok_t      q_data,
  input  wire logic q_pop
);
  tok_t       slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       take;
  logic       keep;
  tok_t       dec;

  // codes six and seven are consumed and dropped here
  always_comb begin
    dec.value = tok.operand_value;
    dec.kind  = OP_PUSH;
    keep      = 1'b1;
    unique case (tok.cmd)
      OP_PUSH:   dec.kind = OP_PUSH;
      OP_ADD:    dec.kind = OP_ADD;
      OP_SUB:    dec.kind = OP_SUB;
      OP_MUL:    dec.kind = OP_MUL;
      OP_DIV:    dec.kind = OP_DIV;
      OP_FINISH: dec.kind = OP_FINISH;
      default:   keep = 1'b0;
    endcase
  end

  assign tok.ready = (fill != 2'd2);
  assign take      = tok.valid && tok.ready && keep;
  assign q_valid   = (fill != 2'd0);
  assign q_data    = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (take) begin
        slot[wp] <= dec;
        wp       <= ~wp;
      end
      if (q_pop && q_valid) rp <= ~rp;
      fill <= fill + 2'(take) - 2'(q_pop && q_valid);
    end
  end
endmodule
`default_nettype wire

@@ rtl/pse_back.sv @@
// Back end: operand stack, arithmetic sequencer and result register.
`default_nettype none
module pse_back
  import pse_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  tok_t      q_data,
  output logic      q_pop,
  pse_res_if.source res
);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(QUO_W);

  bst_t               state, state_next;
  logic [CW-1:0]      count;
  st_t                err;
  logic [WORD_W-1:0]  tos;
  op_t                op;
  logic [2*WORD_W-1:0] prod;
  logic               pneg;
  logic [WORD_W-1:0]  rem;
  logic [QUO_W-1:0]   nq;
  logic [WORD_W-1:0]  dmag;
  logic [DW-1:0]      dcnt;
  logic               out_valid;
  logic [WORD_W-1:0]  out_val;
  st_t                out_st;

  logic [CW-1:0]      cnt_m1, cnt_m2;
  logic               full, is_arith, two_ok, div_last;
  logic               ram_we, ram_re;
  logic [WORD_W-1:0]  ram_rdata;
  logic [WORD_W:0]    sum_add, sum_sub, r2;
  logic               div_take;
  logic [WORD_W:0]    r_next;
  logic [QUO_W-1:0]   nq_next;
  st_t                fin_st;
  logic               fin_take;

  assign cnt_m1   = count - CW'(1);
  assign cnt_m2   = count - CW'(2);
  assign full     = (count >= CW'(STACK_DEPTH));
  assign two_ok   = (count >= CW'(2));
  assign is_arith = q_data.kind inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV};
  assign div_last = (dcnt == DW'(QUO_W - 1));
  assign fin_take = q_pop && (q_data.kind == OP_FINISH);

  assign sum_add = {ram_rdata[WORD_W-1], ram_rdata} + {tos[WORD_W-1], tos};
  assign sum_sub = {ram_rdata[WORD_W-1], ram_rdata} - {tos[WORD_W-1], tos};

  // restoring divide, one quotient bit per cycle
  assign r2       = {rem, nq[QUO_W-1]};
  assign div_take = (r2 >= {1'b0, dmag});
  assign r_next   = div_take ? (r2 - {1'b0, dmag}) : r2;
  assign nq_next  = {nq[QUO_W-2:0], div_take};

  always_comb begin
    if (err != ST_OK)        fin_st = err;
    else if (count == '0)    fin_st = ST_EMPTY;
    else                     fin_st = ST_OK;
  end

  pse_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_m1[AW-1:0]),
    .wdata (tos),
    .re    (ram_re),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  // control outputs
  always_comb begin
    q_pop  = 1'b0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    if (state == S_IDLE && q_valid) begin
      if (q_data.kind == OP_FINISH) q_pop = !out_valid || res.ready;
      else                          q_pop = 1'b1;
    end
    if (q_pop && err == ST_OK) begin
      if (q_data.kind == OP_PUSH && !full && count != '0) ram_we = 1'b1;
      if (is_arith && two_ok)                              ram_re = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (ram_re) state_next = S_EXEC;
      S_EXEC: begin
        if (op == OP_MUL)                  state_next = S_MUL;
        else if (op == OP_DIV && tos != '0) state_next = S_DIV;
        else                               state_next = S_IDLE;
      end
      S_MUL:  state_next = S_IDLE;
      S_DIV:  if (div_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res.valid && res.ready && !fin_take) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (q_pop) begin
          if (q_data.kind == OP_FINISH) begin
            out_valid <= 1'b1;
            out_st    <= fin_st;
            out_val   <= (fin_st == ST_OK) ? tos : '0;
            count     <= '0;
            err       <= ST_OK;
          end else if (err == ST_OK) begin
            if (q_data.kind == OP_PUSH) begin
              if (full) begin
                err <= ST_FULL;
              end else begin
                tos   <= q_data.value;
                count <= count + CW'(1);
              end
            end else if (!two_ok) begin
              err <= ST_MISSING;
            end else begin
              op <= q_data.kind;
            end
          end
        end
        S_EXEC: begin
          pneg <= ram_rdata[WORD_W-1] ^ tos[WORD_W-1];
          case (op)
            OP_ADD: begin
              tos   <= sat_sum(sum_add);
              count <= cnt_m1;
            end
            OP_SUB: begin
              tos   <= sat_sum(sum_sub);
              count <= cnt_m1;
            end
            OP_MUL: begin
              prod  <= mag(ram_rdata) * mag(tos);
              count <= cnt_m1;
            end
            default: begin
              if (tos == '0) begin
                err <= ST_DIVZERO;
              end else begin
                rem   <= '0;
                nq    <= {mag(ram_rdata), {FRAC_W{1'b0}}};
                dmag  <= mag(tos);
                dcnt  <= '0;
                count <= cnt_m1;
              end
            end
          endcase
        end
        S_MUL: tos <= sat_mag(prod[2*WORD_W-1:FRAC_W], pneg);
        S_DIV: begin
          rem  <= r_next[WORD_W-1:0];
          nq   <= nq_next;
          dcnt <= dcnt + DW'(1);
          if (div_last) tos <= sat_mag(nq_next, pneg);
        end
        default: ;
      endcase
    end
  end

  assign res.valid        = out_valid;
  assign res.result_value = out_val;
  assign res.status       = out_st;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !q_pop)
    else $error("token taken while an operator is in progress");

  a_exec_operands: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> (count >= CW'(2)))
    else $error("operator executing with fewer than two operands");

  a_div_enter: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && $past(state) == S_EXEC) |-> (dcnt == '0 && dmag != '0))
    else $error("divider started without a clean setup");
endmodule
`default_nettype wire
